>>> sv/ghnr_pkg.sv
// shared types and constants for the geohash neighbour range generator
package ghnr_pkg;

  localparam int CELL_COUNT = 9;
  localparam int CELL_W     = 4;
  localparam int STEP_BITS  = 5;

  typedef logic [CELL_W-1:0] cell_idx_t;

  // emission order of the cells
  localparam cell_idx_t CELL_CENTER = 4'd0;
  localparam cell_idx_t CELL_N      = 4'd1;
  localparam cell_idx_t CELL_S      = 4'd2;
  localparam cell_idx_t CELL_E      = 4'd3;
  localparam cell_idx_t CELL_W_IDX  = 4'd4;
  localparam cell_idx_t CELL_NE     = 4'd5;
  localparam cell_idx_t CELL_NW     = 4'd6;
  localparam cell_idx_t CELL_SE     = 4'd7;
  localparam cell_idx_t CELL_SW     = 4'd8;

  typedef struct packed {
    logic south;
    logic north;
    logic west;
    logic east;
  } prune_t;

endpackage

>>> sv/ghnr_lane_step.sv
// carry-propagating plus or minus one on one bit lane of an interleaved code
module ghnr_lane_step import ghnr_pkg::*; #(
  parameter int SCORE_BITS = 52
) (
  input  logic [SCORE_BITS-1:0] hash,
  input  logic [SCORE_BITS-1:0] lane,
  input  logic [SCORE_BITS-1:0] fill,
  input  logic                  up,
  output logic [SCORE_BITS-1:0] moved
);

  logic [SCORE_BITS-1:0] v;
  logic [SCORE_BITS-1:0] rest;
  logic [SCORE_BITS-1:0] t;
  logic [SCORE_BITS-1:0] one;

  assign one  = {{(SCORE_BITS-1){1'b0}}, 1'b1};
  assign v    = hash & lane;
  assign rest = hash & ~lane;

  // other lane filled with ones so the carry or borrow hops across it
  always_comb begin
    if (up) begin
      t = v + fill + one;
    end else begin
      t = (v | fill) - (fill + one);
    end
  end

  assign moved = (t & lane) | rest;

endmodule

>>> sv/ghnr_neighbours.sv
// the centre cell, its eight neighbours and which of them survive pruning
module ghnr_neighbours import ghnr_pkg::*; #(
  parameter int SCORE_BITS = 52
) (
  input  logic [SCORE_BITS-1:0] hash,
  input  logic [STEP_BITS-1:0]  step,
  input  prune_t                prune,
  output logic [SCORE_BITS-1:0] cells [CELL_COUNT],
  output logic [CELL_COUNT-1:0] cand
);

  localparam logic [SCORE_BITS-1:0] EVEN_LANE = SCORE_BITS'({32{2'b01}});
  localparam logic [SCORE_BITS-1:0] ODD_LANE  = SCORE_BITS'({32{2'b10}});

  logic [SCORE_BITS-1:0] wmask;
  logic [SCORE_BITS-1:0] even_w;
  logic [SCORE_BITS-1:0] odd_w;
  logic [SCORE_BITS-1:0] north;
  logic [SCORE_BITS-1:0] south;
  logic [SCORE_BITS-1:0] east;
  logic [SCORE_BITS-1:0] west;

  assign wmask  = ~({SCORE_BITS{1'b1}} << {step, 1'b0});
  assign even_w = EVEN_LANE & wmask;
  assign odd_w  = ODD_LANE & wmask;

  // latitude on the even lane, longitude on the odd lane
  ghnr_lane_step #(.SCORE_BITS(SCORE_BITS)) u_north (
    .hash(hash), .lane(even_w), .fill(odd_w), .up(1'b1), .moved(north)
  );
  ghnr_lane_step #(.SCORE_BITS(SCORE_BITS)) u_south (
    .hash(hash), .lane(even_w), .fill(odd_w), .up(1'b0), .moved(south)
  );
  ghnr_lane_step #(.SCORE_BITS(SCORE_BITS)) u_east (
    .hash(hash), .lane(odd_w), .fill(even_w), .up(1'b1), .moved(east)
  );
  ghnr_lane_step #(.SCORE_BITS(SCORE_BITS)) u_west (
    .hash(hash), .lane(odd_w), .fill(even_w), .up(1'b0), .moved(west)
  );

  // lanes are disjoint, so diagonals merge one lane from each move
  always_comb begin
    cells[CELL_CENTER] = hash;
    cells[CELL_N]      = north;
    cells[CELL_S]      = south;
    cells[CELL_E]      = east;
    cells[CELL_W_IDX]  = west;
    cells[CELL_NE]     = (east & odd_w) | (north & even_w);
    cells[CELL_NW]     = (west & odd_w) | (north & even_w);
    cells[CELL_SE]     = (east & odd_w) | (south & even_w);
    cells[CELL_SW]     = (west & odd_w) | (south & even_w);
  end

  always_comb begin
    cand              = '0;
    cand[CELL_CENTER] = 1'b1;
    cand[CELL_N]      = ~prune.north;
    cand[CELL_S]      = ~prune.south;
    cand[CELL_E]      = ~prune.east;
    cand[CELL_W_IDX]  = ~prune.west;
    cand[CELL_NE]     = ~(prune.north | prune.east);
    cand[CELL_NW]     = ~(prune.north | prune.west);
    cand[CELL_SE]     = ~(prune.south | prune.east);
    cand[CELL_SW]     = ~(prune.south | prune.west);
  end

endmodule

>>> sv/ghnr_emitter.sv
// cell bank, skip-ahead sequencing and result registers
module ghnr_emitter import ghnr_pkg::*; #(
  parameter int SCORE_BITS = 52
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load_req,
  input  logic [SCORE_BITS-1:0] load_cells [CELL_COUNT],
  input  logic [CELL_COUNT-1:0] load_cand,
  input  logic [STEP_BITS-1:0]  load_step,
  output logic                  load_ok,
  output logic                  strobe,
  output cell_idx_t             cell_index,
  output logic [SCORE_BITS-1:0] range_min,
  output logic [SCORE_BITS:0]   range_max,
  output logic                  last_range
);

  localparam int SH_W = (SCORE_BITS > 2) ? $clog2(SCORE_BITS) : 1;

  logic                  bank_valid;
  cell_idx_t             pos;
  cell_idx_t             pos_next;
  logic [SCORE_BITS-1:0] cells [CELL_COUNT];
  logic [CELL_COUNT-1:0] cand;
  logic [SH_W-1:0]       sh;
  logic [SCORE_BITS-1:0] cur_cell;
  logic                  cur_last;
  logic                  load;

  assign cur_cell = cells[pos];

  // a later cell goes out if unpruned and unlike the one going out now, unless that one is the centre
  always_comb begin
    cur_last = 1'b1;
    pos_next = pos;
    for (int j = CELL_COUNT - 1; j >= 1; j--) begin
      if (cand[j] && (CELL_W'(j) > pos) &&
          ((pos == CELL_CENTER) || (cells[j] != cur_cell))) begin
        cur_last = 1'b0;
        pos_next = CELL_W'(j);
      end
    end
  end

  assign load_ok = ~bank_valid | cur_last;
  assign load    = load_req & load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= 1'b0;
      pos        <= CELL_CENTER;
    end else if (load) begin
      bank_valid <= 1'b1;
      pos        <= CELL_CENTER;
    end else if (bank_valid) begin
      bank_valid <= ~cur_last;
      pos        <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cells <= load_cells;
      cand  <= load_cand;
      sh    <= SH_W'(SCORE_BITS - 2 * int'(load_step));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= bank_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bank_valid) begin
      cell_index <= pos;
      range_min  <= cur_cell << sh;
      range_max  <= ({1'b0, cur_cell} + {{SCORE_BITS{1'b0}}, 1'b1}) << sh;
      last_range <= cur_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_centre_first: assert property (@(posedge clk) disable iff (rst)
    load |=> ##1 (strobe && cell_index == CELL_CENTER))
    else $error("first range of a beat is not the centre cell");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_range |=> strobe)
    else $error("ranges of one beat are not back to back");

  a_index_rises: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_range |=> cell_index > $past(cell_index))
    else $error("cell index did not advance within a beat");

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    strobe |-> range_max > {1'b0, range_min})
    else $error("range upper bound not above lower bound");
`endif

endmodule

>>> sv/geohash_neighbor_range_generator.sv
// geohash neighbour range generator: input register, cell bank, result registers
// order: a taken beat waits in the input register until the cell bank can load it; its
// ranges are then registered from the bank, one per cycle, 1 to 9 ranges per beat
// throughput: the next beat enters the bank on the cycle of the previous beat's last range
// no result stall; busy means the input register holds a beat the bank cannot take yet
// reset (rst, synchronous): clears the input and bank valid flags and the strobe
module geohash_neighbor_range_generator import ghnr_pkg::*; #(
  parameter int SCORE_BITS = 52
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [SCORE_BITS-1:0] cell_hash,
  input  logic [STEP_BITS-1:0]  precision_step,
  input  logic                  prune_south,
  input  logic                  prune_north,
  input  logic                  prune_west,
  input  logic                  prune_east,
  output logic                  strobe,
  output cell_idx_t             cell_index,
  output logic [SCORE_BITS-1:0] range_min,
  output logic [SCORE_BITS:0]   range_max,
  output logic                  last_range
);

  localparam int MAX_STEP = SCORE_BITS / 2;

  // input register
  logic                  in_valid;
  logic [SCORE_BITS-1:0] in_hash;
  logic [STEP_BITS-1:0]  in_step;
  prune_t                in_prune;

  logic [STEP_BITS-1:0]  step_clamped;
  logic [SCORE_BITS-1:0] wmask;
  logic                  accept;
  logic                  load_ok;

  logic [SCORE_BITS-1:0] cells [CELL_COUNT];
  logic [CELL_COUNT-1:0] cand;

  // step of zero counts as one, steps past half the score width are capped
  always_comb begin
    if (precision_step == '0) begin
      step_clamped = STEP_BITS'(1);
    end else if (int'(precision_step) > MAX_STEP) begin
      step_clamped = STEP_BITS'(MAX_STEP);
    end else begin
      step_clamped = precision_step;
    end
  end

  // hash bits at or above twice the step are dropped on entry
  assign wmask = ~({SCORE_BITS{1'b1}} << {step_clamped, 1'b0});

  // input stage frees up whenever the bank takes its beat
  assign busy   = in_valid & ~load_ok;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (load_ok) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_hash        <= cell_hash & wmask;
      in_step        <= step_clamped;
      in_prune.south <= prune_south;
      in_prune.north <= prune_north;
      in_prune.west  <= prune_west;
      in_prune.east  <= prune_east;
    end
  end

  // neighbour cells and prune mask from the registered beat
  ghnr_neighbours #(.SCORE_BITS(SCORE_BITS)) u_neighbours (
    .hash  (in_hash),
    .step  (in_step),
    .prune (in_prune),
    .cells (cells),
    .cand  (cand)
  );

  // bank walks the surviving cells, skipping repeats, one range per cycle
  ghnr_emitter #(.SCORE_BITS(SCORE_BITS)) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load_req   (in_valid),
    .load_cells (cells),
    .load_cand  (cand),
    .load_step  (in_step),
    .load_ok    (load_ok),
    .strobe     (strobe),
    .cell_index (cell_index),
    .range_min  (range_min),
    .range_max  (range_max),
    .last_range (last_range)
  );

endmodule

>>> tb/testbench.sv
// self-checking testbench for the geohash neighbour range generator
module testbench import ghnr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCORE_W = 52;
  // edges from the last range to an idle block, with some margin
  localparam int DRAIN_TAIL = 8;
  // cycles with neither an input beat nor a range before the run is abandoned
  localparam int STALL_LIMIT = 1000;

  // bit lanes of the interleaved code: latitude on even bits, longitude on odd bits
  localparam logic [63:0] LAT_LANE = 64'h5555_5555_5555_5555;
  localparam logic [63:0] LON_LANE = 64'haaaa_aaaa_aaaa_aaaa;

  // one expected range beat
  typedef struct {
    cell_idx_t          idx;
    logic [SCORE_W-1:0] lo;
    logic [SCORE_W:0]   hi;
    logic               last;
  } range_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [SCORE_W-1:0]   cell_hash = '0;
  logic [STEP_BITS-1:0] precision_step = '0;
  logic                 prune_south = 1'b0;
  logic                 prune_north = 1'b0;
  logic                 prune_west = 1'b0;
  logic                 prune_east = 1'b0;
  logic                 strobe;
  cell_idx_t            cell_index;
  logic [SCORE_W-1:0]   range_min;
  logic [SCORE_W:0]     range_max;
  logic                 last_range;

  range_beat_t pending_ranges[$];
  int          error_count = 0;
  int          stall_cycles = 0;
  // chance in a hundred that the sender idles on a given cycle
  int          sender_idle_pct = 0;

  geohash_neighbor_range_generator #(
    .SCORE_BITS(SCORE_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cell_hash(cell_hash),
    .precision_step(precision_step),
    .prune_south(prune_south),
    .prune_north(prune_north),
    .prune_west(prune_west),
    .prune_east(prune_east),
    .strobe(strobe),
    .cell_index(cell_index),
    .range_min(range_min),
    .range_max(range_max),
    .last_range(last_range)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    error_count++;
  endtask

  // +1 / -1 on one lane of the code; lane and other are already cut to the cell width
  function automatic logic [63:0] lane_step(input logic [63:0] code, input logic [63:0] lane,
                                            input logic [63:0] other, input int dir);
    logic [63:0] v;
    v = code & lane;
    if (dir > 0) begin
      // ones in the other lane let the carry ripple across it
      v = ((v | other) + 64'd1) & lane;
    end else if (dir < 0) begin
      // the borrow lands in the other lane and is masked off
      v = (v - 64'd1) & lane;
    end
    return v | (code & ~lane);
  endfunction

  // works out every range beat that one input beat should produce, in emission order
  function automatic void queue_neighbour_ranges(input logic [SCORE_W-1:0] hash_in,
                                                 input logic [STEP_BITS-1:0] step_in,
                                                 input prune_t prune);
    int unsigned step;
    int unsigned span;
    int unsigned shift;
    int          dx;
    int          dy;
    int          n;
    bit          keep;
    bit          have_prev;
    cell_idx_t   idx;
    logic [63:0] wmask;
    logic [63:0] lon_w;
    logic [63:0] lat_w;
    logic [63:0] centre;
    logic [63:0] nbr;
    logic [63:0] prev_nbr;
    logic [63:0] lo_full;
    logic [63:0] hi_full;
    range_beat_t batch[CELL_COUNT];

    // out-of-range steps are clamped to 1..SCORE_W/2
    step = step_in;
    if (step < 1) step = 1;
    if (step > SCORE_W / 2) step = SCORE_W / 2;
    span = 2 * step;
    shift = SCORE_W - span;
    wmask = (64'd1 << span) - 64'd1;
    lon_w = LON_LANE & wmask;
    lat_w = LAT_LANE & wmask;
    centre = {12'd0, hash_in} & wmask;
    have_prev = 1'b0;
    prev_nbr = '0;
    n = 0;

    for (int i = 0; i < CELL_COUNT; i++) begin
      idx = cell_idx_t'(i);
      case (idx)
        CELL_N:     begin dx = 0;  dy = 1;  end
        CELL_S:     begin dx = 0;  dy = -1; end
        CELL_E:     begin dx = 1;  dy = 0;  end
        CELL_W_IDX: begin dx = -1; dy = 0;  end
        CELL_NE:    begin dx = 1;  dy = 1;  end
        CELL_NW:    begin dx = -1; dy = 1;  end
        CELL_SE:    begin dx = 1;  dy = -1; end
        CELL_SW:    begin dx = -1; dy = -1; end
        default:    begin dx = 0;  dy = 0;  end
      endcase
      keep = 1'b1;
      nbr = centre;
      if (idx != CELL_CENTER) begin
        if ((dy > 0 && prune.north) || (dy < 0 && prune.south) ||
            (dx > 0 && prune.east) || (dx < 0 && prune.west)) begin
          keep = 1'b0;
        end else begin
          // longitude move first, then latitude, each wrapping inside the cell width
          nbr = lane_step(centre, lon_w, lat_w, dx);
          nbr = lane_step(nbr, lat_w, lon_w, dy);
          // only the most recent emitted neighbour is compared, the centre never
          if (have_prev && nbr == prev_nbr) begin
            keep = 1'b0;
          end else begin
            have_prev = 1'b1;
            prev_nbr = nbr;
          end
        end
      end
      if (keep) begin
        lo_full = nbr << shift;
        hi_full = (nbr + 64'd1) << shift;
        batch[n].idx = idx;
        batch[n].lo = lo_full[SCORE_W-1:0];
        batch[n].hi = hi_full[SCORE_W:0];
        batch[n].last = 1'b0;
        n++;
      end
    end
    // the centre is always there, so n is at least one
    batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_ranges.push_back(batch[i]);
  endfunction

  // offers one beat, with random idle cycles ahead of it, and waits until it is taken
  task automatic issue_cell(input logic [SCORE_W-1:0] hash_in,
                            input logic [STEP_BITS-1:0] step_in, input prune_t prune);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cell_hash <= hash_in;
    precision_step <= step_in;
    prune_south <= prune.south;
    prune_north <= prune.north;
    prune_west <= prune.west;
    prune_east <= prune.east;
    @(posedge clk);
    while (busy) @(posedge clk);
    queue_neighbour_ranges(hash_in, step_in, prune);
  endtask

  // holds the sender off until every pending range has come out
  task automatic drain_ranges();
    start <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // clamped steps, empty and full codes, high bits that must be ignored
  task automatic test_step_and_hash_extremes();
    issue_cell('0, 5'd0, '0);
    issue_cell('1, 5'd31, '0);
    issue_cell('1, 5'd26, '0);
    issue_cell('0, 5'd26, '0);
    issue_cell('1, 5'd27, '0);
    issue_cell(LON_LANE[SCORE_W-1:0], 5'd13, '0);
  endtask

  // every combination of the four prune flags on tiny grids, where neighbours repeat
  task automatic test_prune_patterns();
    logic [63:0] r;
    for (int k = 0; k < 16; k++) begin
      r = {$urandom(), $urandom()};
      issue_cell(r[SCORE_W-1:0], STEP_BITS'(1 + (k % 2)), prune_t'(k));
    end
  endtask

  // random cells: mostly legal steps, some clamped, some codes pinned to a grid edge
  task automatic test_random_cells(input int count, input int idle_pct);
    logic [63:0]          r;
    logic [STEP_BITS-1:0] st;
    prune_t               p;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < count; k++) begin
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
        0:       st = STEP_BITS'($urandom_range(0, 31));
        1:       st = STEP_BITS'($urandom_range(1, 3));
        default: st = STEP_BITS'($urandom_range(1, 26));
      endcase
      // pinning a lane to all ones or all zeros forces wrap at the edges
      case ($urandom_range(0, 7))
        0:       r = r | LON_LANE;
        1:       r = r & ~LON_LANE;
        2:       r = r | LAT_LANE;
        3:       r = r & ~LAT_LANE;
        default: ;
      endcase
      p = prune_t'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 0) p = '0;
      issue_cell(r[SCORE_W-1:0], st, p);
    end
  endtask

  // compares each range beat with the oldest expectation
  always @(posedge clk) begin
    range_beat_t want;
    if (!rst && strobe) begin
      if (pending_ranges.size() == 0) begin
        flag_mismatch("range beat with nothing pending", '0, {60'd0, cell_index});
      end else begin
        want = pending_ranges.pop_front();
        if (cell_index !== want.idx)
          flag_mismatch("cell_index", {60'd0, want.idx}, {60'd0, cell_index});
        if (range_min !== want.lo)
          flag_mismatch("range_min", {12'd0, want.lo}, {12'd0, range_min});
        if (range_max !== want.hi)
          flag_mismatch("range_max", {11'd0, want.hi}, {11'd0, range_max});
        if (last_range !== want.last)
          flag_mismatch("last_range", {63'd0, want.last}, {63'd0, last_range});
      end
    end
  end

  // watchdog: gives up when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 0;
    test_step_and_hash_extremes();
    test_prune_patterns();
    drain_ranges();

    // sender idles now and then
    test_random_cells(46, 20);
    drain_ranges();
    // sender idles most of the time
    test_random_cells(46, 86);
    drain_ranges();
    // back-to-back beats
    test_random_cells(46, 0);
    drain_ranges();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ghnr_pkg.sv
sv/ghnr_lane_step.sv
sv/ghnr_neighbours.sv
sv/ghnr_emitter.sv
sv/geohash_neighbor_range_generator.sv
tb/testbench.sv
